// ----- sv/grm_pkg.sv -----
package grm_pkg;

   // ray march geometry
   localparam int MAX_RANGE   = 512;
   localparam int RAY_STEP    = 2;
   localparam int CELL_SIZE   = 32;
   localparam int MAP_SIDE    = 16;
   localparam int EXTENT      = MAP_SIDE * CELL_SIZE;
   localparam int HEIGHT_NUM  = 10000;
   localparam int SCREEN_ROWS = 512;

   // field widths
   localparam int COORD_W  = 9;
   localparam int ANGLE_W  = 12;
   localparam int DIST_W   = 10;
   localparam int HEIGHT_W = 10;
   localparam int TOP_W    = 9;

   // trig and position formats
   localparam int FRAC_BITS  = 14;
   localparam int QUARTER    = 1024;
   localparam int ROM_AW     = $clog2(QUARTER + 1);
   localparam int SINE_MAG_W = FRAC_BITS + 1;
   localparam int TRIG_W     = FRAC_BITS + 2;
   localparam int POS_W      = FRAC_BITS + $clog2(MAX_RANGE) + 3;
   localparam int PIX_W      = POS_W - FRAC_BITS;
   localparam int STEP_SHIFT = $clog2(RAY_STEP);
   localparam int CELL_W     = $clog2(CELL_SIZE);
   localparam int MAP_W      = $clog2(MAP_SIDE);

   // occupancy map: 16 cells per row, 4 rows per 64-bit register
   localparam int CSR_W      = 64;
   localparam int CSR_COUNT  = 4;
   localparam int CSR_IDX_W  = $clog2(CSR_COUNT);
   localparam int MAP_BITS   = CSR_W * CSR_COUNT;
   localparam int MAP_IDX_W  = $clog2(MAP_BITS);
   localparam int ROW_BITS   = MAP_BITS / 16;

   // divider
   localparam int NUM_W  = $clog2(HEIGHT_NUM + 1);
   localparam int STEP_W = $clog2(NUM_W + 1);

   // queue between front and back
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_MAP_ROWS_0_TO_3,
      CSR_MAP_ROWS_4_TO_7,
      CSR_MAP_ROWS_8_TO_11,
      CSR_MAP_ROWS_12_TO_15
   } grm_csr_index_type;

   typedef enum logic [1:0] {
      FR_IDLE,
      FR_SIN,
      FR_COS,
      FR_PUSH
   } grm_front_state_type;

   typedef enum logic [1:0] {
      BK_IDLE,
      BK_MARCH,
      BK_DIVIDE,
      BK_LOAD
   } grm_back_state_type;

   typedef struct packed {
      logic [COORD_W-1:0]       origin_x;
      logic [COORD_W-1:0]       origin_y;
      logic signed [TRIG_W-1:0] sine;
      logic signed [TRIG_W-1:0] cosine;
   } grm_ray_type;

   // quarter-wave sine, Q14, built at elaboration from a Q30 Taylor series
   localparam logic [63:0] Q30_ONE     = 64'd1073741824;
   localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
   localparam logic [63:0] ROUND_HALF  = 64'd32768;
   localparam int          TAYLOR_TOP  = 13;

   typedef logic [SINE_MAG_W-1:0] sine_table_type [QUARTER+1];

   function automatic sine_table_type build_sine_table();
      sine_table_type tbl;
      logic [63:0]    x;
      logic [63:0]    x2;
      logic [63:0]    t;
      logic [63:0]    s;
      for (int k = 0; k <= QUARTER; k++) begin
         x  = (64'(k) * HALF_PI_Q30) >> 10;
         x2 = (x * x) >> 30;
         t  = Q30_ONE;
         for (int n = TAYLOR_TOP; n >= 3; n -= 2) begin
            t = Q30_ONE - (((x2 * t) >> 30) / 64'(n * (n - 1)));
         end
         s      = (x * t) >> 30;
         tbl[k] = SINE_MAG_W'((s + ROUND_HALF) >> 16);
      end
      return tbl;
   endfunction

   localparam sine_table_type SINE_TABLE = build_sine_table();

endpackage

// ----- sv/grm_if.sv -----
interface grm_req_if import grm_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [COORD_W-1:0] origin_x;
   logic [COORD_W-1:0] origin_y;
   logic [ANGLE_W-1:0] ray_angle;

   modport source (output valid, output origin_x, output origin_y, output ray_angle,
                   input ready);
   modport sink   (input valid, input origin_x, input origin_y, input ray_angle,
                   output ready);
endinterface

interface grm_rsp_if import grm_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [DIST_W-1:0]   hit_distance;
   logic                wall_hit;
   logic [HEIGHT_W-1:0] wall_height;
   logic [TOP_W-1:0]    wall_top;

   modport source (output valid, output hit_distance, output wall_hit,
                   output wall_height, output wall_top, input ready);
   modport sink   (input valid, input hit_distance, input wall_hit,
                   input wall_height, input wall_top, output ready);
endinterface

interface grm_csr_if import grm_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [CSR_IDX_W-1:0] index;
   logic [CSR_W-1:0]     data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- sv/grid_ray_march_wall_height_top.sv -----
// Response time grows with the hit distance: the back end marches one step per cycle
//   until a hit or the range end, then runs the restoring divider for the height.
// The divider is skipped for a hit at the origin. The front end overlaps the back end,
//   taking the next ray into the queue while the back end is still busy.
// Reset: synchronous, active high; clears all control state and the four map
//   registers (empty map). No clearing pass.
module grid_ray_march_wall_height_top import grm_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   grm_req_if.sink    req_chan,
   grm_rsp_if.source  rsp_chan,
   grm_csr_if.sink    csr_chan
);

   // Structure:
   //   front - takes a request word, looks up sine and cosine in the quarter-wave
   //           ROM (one registered read each), pushes the ray into the queue.
   //   queue - two-entry FIFO so the front can take the next ray while the back
   //           is still marching.
   //   back  - fixed-step march (incremental adds, no multiply), then
   //           restoring divide for the wall height, then output register.

   logic [CSR_W-1:0]    map_ff [CSR_COUNT];
   logic [MAP_BITS-1:0] map_bits;

   logic        push_valid;
   logic        push_ready;
   grm_ray_type push_ray;
   logic        pop_valid;
   logic        pop_ready;
   grm_ray_type pop_ray;

   // map registers: always ready, a write shows on the map in the next cycle
   assign csr_chan.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < CSR_COUNT; i++) begin
            map_ff[i] <= '0;
         end
      end else if (csr_chan.valid) begin
         case (csr_chan.index)
            CSR_MAP_ROWS_0_TO_3:   map_ff[0] <= csr_chan.data;
            CSR_MAP_ROWS_4_TO_7:   map_ff[1] <= csr_chan.data;
            CSR_MAP_ROWS_8_TO_11:  map_ff[2] <= csr_chan.data;
            CSR_MAP_ROWS_12_TO_15: map_ff[3] <= csr_chan.data;
            default: begin
            end
         endcase
      end
   end

   // flat map: cell (row r, column c) is bit r*16 + c
   assign map_bits = {map_ff[3], map_ff[2], map_ff[1], map_ff[0]};

   grm_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_chan   (req_chan),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_ray   (push_ray)
   );

   grm_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_ray   (push_ray),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_ray    (pop_ray)
   );

   grm_back u_back (
      .clock     (clock),
      .reset     (reset),
      .pop_valid (pop_valid),
      .pop_ready (pop_ready),
      .pop_ray   (pop_ray),
      .map_bits  (map_bits),
      .rsp_chan  (rsp_chan)
   );

`ifndef SYNTHESIS
   // top row always follows from the height
   assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid |->
         (rsp_chan.wall_top ==
          TOP_W'((HEIGHT_W'(SCREEN_ROWS) - rsp_chan.wall_height) >> 1)))
      else $error("wall_top inconsistent with wall_height");

   // a miss reports full range and its fixed height
   assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && !rsp_chan.wall_hit) |->
         ((rsp_chan.hit_distance == DIST_W'(MAX_RANGE)) &&
          (rsp_chan.wall_height == HEIGHT_W'(HEIGHT_NUM / MAX_RANGE))))
      else $error("miss with wrong distance or height");

   // a hit lands on an even step inside the range
   assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && rsp_chan.wall_hit) |->
         ((rsp_chan.hit_distance[0] == 1'b0) &&
          (rsp_chan.hit_distance < DIST_W'(MAX_RANGE))))
      else $error("hit distance off the step grid");
`endif

endmodule

// ----- sv/grm_front.sv -----
module grm_front import grm_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   grm_req_if.sink     req_chan,
   output logic        push_valid,
   input  logic        push_ready,
   output grm_ray_type push_ray
);

   grm_front_state_type    state_ff, state_in;
   logic [COORD_W-1:0]     ox_ff, ox_in;
   logic [COORD_W-1:0]     oy_ff, oy_in;
   logic [ANGLE_W-1:0]     angle_ff, angle_in;
   logic signed [TRIG_W-1:0] sine_ff, sine_in;
   logic [SINE_MAG_W-1:0]  rom_q_ff;
   logic [ROM_AW-1:0]      rom_addr;
   logic [ANGLE_W-1:0]     cos_angle;

   // mirror the quarter index in odd quadrants
   function automatic logic [ROM_AW-1:0] quarter_index(input logic [ANGLE_W-1:0] a);
      logic [ROM_AW-1:0] r;
      r = ROM_AW'(a[ANGLE_W-3:0]);
      return a[ANGLE_W-2] ? ROM_AW'(QUARTER) - r : r;
   endfunction

   function automatic logic signed [TRIG_W-1:0] apply_sign(
      input logic [SINE_MAG_W-1:0] mag, input logic neg);
      logic signed [TRIG_W-1:0] v;
      v = TRIG_W'(mag);
      return neg ? -v : v;
   endfunction

   assign cos_angle = angle_ff + ANGLE_W'(QUARTER);
   assign rom_addr  = (state_ff == FR_SIN) ? quarter_index(angle_ff)
                                           : quarter_index(cos_angle);

   always_ff @(posedge clock) begin
      rom_q_ff <= SINE_TABLE[rom_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= FR_IDLE;
      end else begin
         state_ff <= state_in;
      end
      ox_ff    <= ox_in;
      oy_ff    <= oy_in;
      angle_ff <= angle_in;
      sine_ff  <= sine_in;
   end

   always_comb begin
      state_in       = state_ff;
      ox_in          = ox_ff;
      oy_in          = oy_ff;
      angle_in       = angle_ff;
      sine_in        = sine_ff;
      req_chan.ready = 1'b0;
      push_valid     = 1'b0;
      case (state_ff)
         FR_IDLE: begin
            req_chan.ready = 1'b1;
            if (req_chan.valid) begin
               ox_in    = req_chan.origin_x;
               oy_in    = req_chan.origin_y;
               angle_in = req_chan.ray_angle;
               state_in = FR_SIN;
            end
         end
         FR_SIN: begin
            state_in = FR_COS;
         end
         FR_COS: begin
            sine_in  = apply_sign(rom_q_ff, angle_ff[ANGLE_W-1]);
            state_in = FR_PUSH;
         end
         FR_PUSH: begin
            // rom address holds on the cosine index, so the data is stable
            push_valid = 1'b1;
            if (push_ready) begin
               state_in = FR_IDLE;
            end
         end
         default: begin
            state_in = FR_IDLE;
         end
      endcase
   end

   assign push_ray.origin_x = ox_ff;
   assign push_ray.origin_y = oy_ff;
   assign push_ray.sine     = sine_ff;
   assign push_ray.cosine   = apply_sign(rom_q_ff, cos_angle[ANGLE_W-1]);

endmodule

// ----- sv/grm_queue.sv -----
module grm_queue import grm_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        push_valid,
   output logic        push_ready,
   input  grm_ray_type push_ray,
   output logic        pop_valid,
   input  logic        pop_ready,
   output grm_ray_type pop_ray
);

   grm_ray_type        entries_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]  count_ff, count_in;
   logic               do_push;
   logic               do_pop;

   assign push_ready = (count_ff != QCNT_W'(QUEUE_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_ray    = entries_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= push_ray;
      end
   end

endmodule

// ----- sv/grm_back.sv -----
module grm_back import grm_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                pop_valid,
   output logic                pop_ready,
   input  grm_ray_type         pop_ray,
   input  logic [MAP_BITS-1:0] map_bits,
   grm_rsp_if.source           rsp_chan
);

   localparam logic [DIST_W-1:0] LAST_D = DIST_W'(MAX_RANGE - RAY_STEP);

   grm_back_state_type       state_ff, state_in;
   logic [DIST_W-1:0]        d_ff, d_in;
   logic signed [POS_W-1:0]  vx_ff, vx_in;
   logic signed [POS_W-1:0]  vy_ff, vy_in;
   logic signed [POS_W-1:0]  step_x_ff, step_x_in;
   logic signed [POS_W-1:0]  step_y_ff, step_y_in;
   logic [DIST_W-1:0]        dist_ff, dist_in;
   logic                     hit_ff, hit_in;
   logic [DIST_W-1:0]        rem_ff, rem_in;
   logic [NUM_W-1:0]         quo_ff, quo_in;
   logic [STEP_W-1:0]        cnt_ff, cnt_in;

   logic                     rsp_valid_ff, rsp_valid_in;
   logic [DIST_W-1:0]        rsp_dist_ff, rsp_dist_in;
   logic                     rsp_hit_ff, rsp_hit_in;
   logic [HEIGHT_W-1:0]      rsp_height_ff, rsp_height_in;
   logic [TOP_W-1:0]         rsp_top_ff, rsp_top_in;

   logic [PIX_W-1:0]         px;
   logic [PIX_W-1:0]         py;
   logic [MAP_IDX_W-1:0]     cell_idx;
   logic                     point_hit;
   logic [DIST_W:0]          shifted;
   logic [DIST_W:0]          trial;
   logic [HEIGHT_W-1:0]      height;
   logic                     out_free;

   // sample point test: negative, past the map edge, or a wall cell
   assign px        = vx_ff[POS_W-1:FRAC_BITS];
   assign py        = vy_ff[POS_W-1:FRAC_BITS];
   assign cell_idx  = MAP_IDX_W'({py[CELL_W +: MAP_W], px[CELL_W +: MAP_W]});
   assign point_hit = vx_ff[POS_W-1] || vy_ff[POS_W-1]
                   || (px >= PIX_W'(EXTENT)) || (py >= PIX_W'(EXTENT))
                   || map_bits[cell_idx];

   // restoring divider, one quotient bit per cycle
   assign shifted = {rem_ff, quo_ff[NUM_W-1]};
   assign trial   = shifted - {1'b0, dist_ff};

   assign height  = (quo_ff > NUM_W'(SCREEN_ROWS)) ? HEIGHT_W'(SCREEN_ROWS)
                                                   : quo_ff[HEIGHT_W-1:0];
   assign out_free = !rsp_valid_ff || rsp_chan.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      d_ff          <= d_in;
      vx_ff         <= vx_in;
      vy_ff         <= vy_in;
      step_x_ff     <= step_x_in;
      step_y_ff     <= step_y_in;
      dist_ff       <= dist_in;
      hit_ff        <= hit_in;
      rem_ff        <= rem_in;
      quo_ff        <= quo_in;
      cnt_ff        <= cnt_in;
      rsp_dist_ff   <= rsp_dist_in;
      rsp_hit_ff    <= rsp_hit_in;
      rsp_height_ff <= rsp_height_in;
      rsp_top_ff    <= rsp_top_in;
   end

   always_comb begin
      state_in      = state_ff;
      d_in          = d_ff;
      vx_in         = vx_ff;
      vy_in         = vy_ff;
      step_x_in     = step_x_ff;
      step_y_in     = step_y_ff;
      dist_in       = dist_ff;
      hit_in        = hit_ff;
      rem_in        = rem_ff;
      quo_in        = quo_ff;
      cnt_in        = cnt_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_chan.ready;
      rsp_dist_in   = rsp_dist_ff;
      rsp_hit_in    = rsp_hit_ff;
      rsp_height_in = rsp_height_ff;
      rsp_top_in    = rsp_top_ff;
      pop_ready     = 1'b0;
      case (state_ff)
         BK_IDLE: begin
            pop_ready = 1'b1;
            if (pop_valid) begin
               d_in      = '0;
               vx_in     = POS_W'({pop_ray.origin_x, {FRAC_BITS{1'b0}}});
               vy_in     = POS_W'({pop_ray.origin_y, {FRAC_BITS{1'b0}}});
               step_x_in = POS_W'(pop_ray.cosine) <<< STEP_SHIFT;
               step_y_in = POS_W'(pop_ray.sine) <<< STEP_SHIFT;
               state_in  = BK_MARCH;
            end
         end
         BK_MARCH: begin
            if (point_hit || (d_ff == LAST_D)) begin
               dist_in = point_hit ? d_ff : DIST_W'(MAX_RANGE);
               hit_in  = point_hit;
               rem_in  = '0;
               cnt_in  = STEP_W'(NUM_W);
               if (point_hit && (d_ff == '0)) begin
                  // hit at the origin: height saturates, no divide
                  quo_in   = NUM_W'(SCREEN_ROWS);
                  state_in = BK_LOAD;
               end else begin
                  quo_in   = NUM_W'(HEIGHT_NUM);
                  state_in = BK_DIVIDE;
               end
            end else begin
               d_in  = d_ff + DIST_W'(RAY_STEP);
               vx_in = vx_ff + step_x_ff;
               vy_in = vy_ff + step_y_ff;
            end
         end
         BK_DIVIDE: begin
            if (shifted >= {1'b0, dist_ff}) begin
               rem_in = trial[DIST_W-1:0];
               quo_in = {quo_ff[NUM_W-2:0], 1'b1};
            end else begin
               rem_in = shifted[DIST_W-1:0];
               quo_in = {quo_ff[NUM_W-2:0], 1'b0};
            end
            cnt_in = cnt_ff - 1'b1;
            if (cnt_ff == STEP_W'(1)) begin
               state_in = BK_LOAD;
            end
         end
         BK_LOAD: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_dist_in   = dist_ff;
               rsp_hit_in    = hit_ff;
               rsp_height_in = height;
               rsp_top_in    = TOP_W'((HEIGHT_W'(SCREEN_ROWS) - height) >> 1);
               state_in      = BK_IDLE;
            end
         end
         default: begin
            state_in = BK_IDLE;
         end
      endcase
   end

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.hit_distance = rsp_dist_ff;
   assign rsp_chan.wall_hit     = rsp_hit_ff;
   assign rsp_chan.wall_height  = rsp_height_ff;
   assign rsp_chan.wall_top     = rsp_top_ff;

endmodule
